>>> design/eilc_pkg.sv
// Shared types and constants for the external interrupt line controller.
package eilc_pkg;

    // Line and port geometry
    localparam int LINE_COUNT = 16;
    localparam int MAX_PORTS  = 4;
    localparam int NUM_PORTS  = 4;
    localparam int SRC_W      = 4;
    localparam int PORT_IDX_W = $clog2(MAX_PORTS);
    localparam int IRQ_COUNT  = 7;

    // Stream payload widths
    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 24;

    // Configuration port
    localparam int CFG_DATA_W = 64;
    localparam int CFG_ADDR_W = 5;
    localparam int REG_IDX_W  = 2;

    localparam logic [REG_IDX_W-1:0] REG_RISING_ENABLE  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_FALLING_ENABLE = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_LINE_UNMASK    = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_LINE_SOURCE    = 2'd3;

    // Request grouping
    localparam logic [LINE_COUNT-1:0] DIRECT_MASK     = 16'h001f;
    localparam logic [LINE_COUNT-1:0] GROUP_LOW_MASK  = 16'h03e0;
    localparam logic [LINE_COUNT-1:0] GROUP_HIGH_MASK = 16'hfc00;
    localparam int DIRECT_COUNT = 5;

    // Per-line configuration handed to each lane
    typedef struct packed {
        logic             rise;
        logic             fall;
        logic [SRC_W-1:0] src;
    } lane_cfg_t;

endpackage

>>> design/external_interrupt_line_controller.sv
// Top level of the sixteen-line external interrupt controller.
//
//  channel   dir   handshake           contents
//  s_*       in    s_tvalid/s_tready   four port pin words and a clear mask
//  m_*       out   m_tvalid/m_tready   pending flags and interrupt requests
//  apb       in    psel/penable        enables, unmask and line sources
//
// One item per cycle while s_tready is high: all sixteen lanes finish a tick in
// the accept cycle and the result is registered in the output or skid register.
// A skid register takes one more item while the output stalls; s_tready
// drops only when both are full.
// Reset clears configuration, previous levels, pending flags and the
// primed flag; the first item after reset detects no edges.
module external_interrupt_line_controller
    import eilc_pkg::*;
#(
    parameter int PORT_COUNT = NUM_PORTS
)
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // port0_pins, port1_pins, port2_pins, port3_pins, clear_pending (16 each)
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // pending_bits[15:0], irq_requests[22:16], zero pad[23]
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [LINE_COUNT-1:0]         rising_enable_reg;
    logic [LINE_COUNT-1:0]         falling_enable_reg;
    logic [LINE_COUNT-1:0]         line_unmask_reg;
    logic [SRC_W*LINE_COUNT-1:0]   line_source_reg;
    logic                          primed_reg;
    logic [OUT_DATA_W-1:0]         out_data_reg;
    logic                          out_valid_reg;
    logic [OUT_DATA_W-1:0]         skid_data_reg;
    logic                          skid_valid_reg;

    logic                          cfg_write;
    logic [REG_IDX_W-1:0]          cfg_idx;
    logic                          s_accept;
    logic                          out_take;
    logic [LINE_COUNT-1:0]         clear_mask;
    logic [LINE_COUNT-1:0]         pending_next;
    logic [IRQ_COUNT-1:0]          irq;
    logic [OUT_DATA_W-1:0]         result;

    // Configuration port
    assign pready    = 1'b1;
    assign cfg_idx   = paddr[CFG_ADDR_W-1:CFG_ADDR_W-REG_IDX_W];
    assign cfg_write = psel & penable & pwrite & pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rising_enable_reg  <= '0;
            falling_enable_reg <= '0;
            line_unmask_reg    <= '0;
            line_source_reg    <= '0;
        end else if (cfg_write) begin
            unique case (cfg_idx)
                REG_RISING_ENABLE:  rising_enable_reg  <= pwdata[LINE_COUNT-1:0];
                REG_FALLING_ENABLE: falling_enable_reg <= pwdata[LINE_COUNT-1:0];
                REG_LINE_UNMASK:    line_unmask_reg    <= pwdata[LINE_COUNT-1:0];
                REG_LINE_SOURCE:    line_source_reg    <= pwdata[SRC_W*LINE_COUNT-1:0];
                default:            ;
            endcase
        end
    end

    // Register readback
    always_comb begin
        unique case (cfg_idx)
            REG_RISING_ENABLE:  prdata = CFG_DATA_W'(rising_enable_reg);
            REG_FALLING_ENABLE: prdata = CFG_DATA_W'(falling_enable_reg);
            REG_LINE_UNMASK:    prdata = CFG_DATA_W'(line_unmask_reg);
            REG_LINE_SOURCE:    prdata = CFG_DATA_W'(line_source_reg);
            default:            prdata = '0;
        endcase
    end

    // Handshakes
    assign s_tready = ~skid_valid_reg;
    assign s_accept = s_tvalid & s_tready;
    assign out_take = out_valid_reg & m_tready;
    assign clear_mask = s_tdata[MAX_PORTS*LINE_COUNT +: LINE_COUNT];

    // Sixteen lanes, one per line
    for (genvar k = 0; k < LINE_COUNT; k++) begin : g_lane
        logic [MAX_PORTS-1:0] lane_pins;
        lane_cfg_t            lane_cfg;

        for (genvar p = 0; p < MAX_PORTS; p++) begin : g_pin
            assign lane_pins[p] = s_tdata[p*LINE_COUNT + k];
        end

        assign lane_cfg.rise = rising_enable_reg[k];
        assign lane_cfg.fall = falling_enable_reg[k];
        assign lane_cfg.src  = line_source_reg[k*SRC_W +: SRC_W];

        eilc_lane #(
            .PORT_COUNT (PORT_COUNT)
        ) u_lane (
            .aclk         (aclk),
            .aresetn      (aresetn),
            .pins         (lane_pins),
            .cfg          (lane_cfg),
            .primed       (primed_reg),
            .clear        (clear_mask[k]),
            .advance      (s_accept),
            .pending_next (pending_next[k])
        );
    end

    // Combine lanes into requests
    eilc_merge u_merge (
        .pending (pending_next),
        .unmask  (line_unmask_reg),
        .irq     (irq)
    );

    assign result = {1'b0, irq, pending_next};

    // Mark the first tick as seen
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            primed_reg <= 1'b0;
        end else if (s_accept) begin
            primed_reg <= 1'b1;
        end
    end

    // Output register with skid stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (out_take) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end else if (s_accept) begin
            if (!out_valid_reg || m_tready) begin
                out_valid_reg <= 1'b1;
            end else begin
                skid_valid_reg <= 1'b1;
            end
        end else if (out_take) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (out_take) begin
                out_data_reg <= skid_data_reg;
            end
        end else if (s_accept) begin
            if (!out_valid_reg || m_tready) begin
                out_data_reg <= result;
            end else begin
                skid_data_reg <= result;
            end
        end
    end

    assign m_tdata  = out_data_reg;
    assign m_tvalid = out_valid_reg;

endmodule

>>> design/eilc_lane.sv
// One interrupt line: pin select, edge detect and pending flag.
module eilc_lane
    import eilc_pkg::*;
#(
    parameter int PORT_COUNT = NUM_PORTS
)
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [MAX_PORTS-1:0] pins,
    input  lane_cfg_t            cfg,
    input  logic                 primed,
    input  logic                 clear,
    input  logic                 advance,
    output logic                 pending_next
);

    logic prev_level_reg;
    logic pending_reg;
    logic level;
    logic edge_hit;

    // Pick the pin of the selected port; missing ports read low
    always_comb begin
        level = 1'b0;
        if (cfg.src < SRC_W'(PORT_COUNT)) begin
            level = pins[cfg.src[PORT_IDX_W-1:0]];
        end
    end

    // Detect enabled edges once the previous level is known
    assign edge_hit = primed & ((level & ~prev_level_reg & cfg.rise) |
                                (~level & prev_level_reg & cfg.fall));

    // Clear first, then let a new edge set the flag
    assign pending_next = (pending_reg & ~clear) | edge_hit;

    // Advance line state on each accepted item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_level_reg <= 1'b0;
            pending_reg    <= 1'b0;
        end else if (advance) begin
            prev_level_reg <= level;
            pending_reg    <= pending_next;
        end
    end

endmodule

>>> design/eilc_merge.sv
// Merge lane pending flags into the seven interrupt requests.
module eilc_merge
    import eilc_pkg::*;
(
    input  logic [LINE_COUNT-1:0] pending,
    input  logic [LINE_COUNT-1:0] unmask,
    output logic [IRQ_COUNT-1:0]  irq
);

    logic [LINE_COUNT-1:0] active;

    assign active = pending & unmask;

    // Direct lines first, then the two shared vectors
    assign irq[DIRECT_COUNT-1:0] = active[DIRECT_COUNT-1:0] & DIRECT_MASK[DIRECT_COUNT-1:0];
    assign irq[DIRECT_COUNT]     = |(active & GROUP_LOW_MASK);
    assign irq[DIRECT_COUNT+1]   = |(active & GROUP_HIGH_MASK);

endmodule

>>> design/eilc_checker.sv
// Port-level checks for the external interrupt line controller, bound to the top.
module eilc_checker
    import eilc_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic [OUT_DATA_W-1:0] m_tdata,
    input logic                  m_tvalid,
    input logic                  m_tready
);

    // Hold a stalled item
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // A direct request needs its own pending flag
    a_direct_irq: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tdata[20:16] & ~m_tdata[4:0]) == 5'd0))
        else $error("direct request without pending flag");

    // Shared low vector needs a pending flag among lines five to nine
    a_group_low: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[21] |-> (m_tdata[9:5] != 5'd0))
        else $error("low group request without pending flag");

    // Shared high vector needs a pending flag among lines ten to fifteen
    a_group_high: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[22] |-> (m_tdata[15:10] != 6'd0))
        else $error("high group request without pending flag");

endmodule

bind external_interrupt_line_controller eilc_checker u_eilc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);
